// ===== rtl/core/wraparound_interval_timer_unit_assert.svh =====
// assertion macros for the wraparound interval timer
// used by wit_ctrl and wit_datapath, no other dependencies
`ifndef WRAPAROUND_INTERVAL_TIMER_UNIT_ASSERT_SVH
`define WRAPAROUND_INTERVAL_TIMER_UNIT_ASSERT_SVH

`ifndef SYNTH
// property holds at every clock edge outside reset
`define WIT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define WIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WIT_ASSERT(lbl, clk, rstn, prop)
`define WIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/wit_pkg.sv =====
// shared types for the wraparound interval timer
// command and status groups between wit_ctrl and wit_datapath
`timescale 1ns / 1ps
`default_nettype none

package wit_pkg;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic step;
        logic save_loop;
        logic save_prog;
        logic out_load;
    } wit_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } wit_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/wit_ctrl.sv =====
// sequencing controller for the wraparound interval timer
// depends on wit_pkg and wraparound_interval_timer_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

module wit_ctrl #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wit_pkg::wit_status_t status,
    output wit_pkg::wit_cmd_t         cmd
);
    import wit_pkg::*;

`include "wraparound_interval_timer_unit_assert.svh"

    localparam int QW   = (COUNT_WIDTH > FRACTION_BITS) ? COUNT_WIDTH : FRACTION_BITS;
    localparam int CNTW = $clog2(QW);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOP   = 7'b0000010,
        ST_SAVE   = 7'b0000100,
        ST_PROG   = 7'b0001000,
        ST_LDLF   = 7'b0010000,
        ST_LFRAC  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } wit_state_t;

    wit_state_t       state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    cnt_next      = CNTW'(COUNT_WIDTH - 1);
                    state_next    = ST_LOOP;
                end
            end
            ST_LOOP: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SAVE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SAVE: begin
                cmd.save_loop = 1'b1;
                cnt_next      = CNTW'(FRACTION_BITS - 1);
                state_next    = ST_PROG;
            end
            ST_PROG: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_LDLF;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_LDLF: begin
                cmd.save_prog = 1'b1;
                cnt_next      = CNTW'(FRACTION_BITS - 1);
                state_next    = ST_LFRAC;
            end
            ST_LFRAC: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register frees up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `WIT_ASSERT(a_load_in_idle, aclk, aresetn, !cmd.load_item || state_reg == ST_IDLE)
    `WIT_ASSERT_NEXT(a_loop_to_save, aclk, aresetn,
        state_reg == ST_LOOP && cnt_reg == '0, state_reg == ST_SAVE)
    `WIT_ASSERT(a_load_when_free, aclk, aresetn, !cmd.out_load || status.out_free)

endmodule

`default_nettype wire

// ===== rtl/core/wit_datapath.sv =====
// datapath of the wraparound interval timer: start mark, timeout register,
// shared restoring divider and output register; depends on wit_pkg
`timescale 1ns / 1ps
`default_nettype none

module wit_datapath #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    input  wire logic [COUNT_WIDTH-1:0]     cfg_timeout_period,
    input  wire logic [COUNT_WIDTH-1:0]     s_now_count,
    input  wire logic                       s_restart,
    input  wire wit_pkg::wit_cmd_t          cmd,
    output wit_pkg::wit_status_t            status,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [COUNT_WIDTH-1:0]          m_elapsed_ticks,
    output logic [COUNT_WIDTH-1:0]          m_remaining_ticks,
    output logic                            m_timed_out,
    output logic [FRACTION_BITS:0]          m_progress_fraction,
    output logic [COUNT_WIDTH-1:0]          m_loop_count,
    output logic [FRACTION_BITS-1:0]        m_loop_fraction,
    output logic                            m_divide_error
);
    import wit_pkg::*;

`include "wraparound_interval_timer_unit_assert.svh"

    localparam int QW = (COUNT_WIDTH > FRACTION_BITS) ? COUNT_WIDTH : FRACTION_BITS;

    logic [COUNT_WIDTH-1:0]   timeout_reg;
    logic [COUNT_WIDTH-1:0]   start_reg, start_next;
    logic [COUNT_WIDTH-1:0]   elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0]   remaining_reg;
    logic                     tout_reg, derr_reg;
    logic [COUNT_WIDTH-1:0]   rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]   div_reg;
    logic [QW-1:0]            quo_reg;
    logic [COUNT_WIDTH-1:0]   loop_q_reg, loop_r_reg;
    logic [FRACTION_BITS-1:0] prog_q_reg;
    logic                     m_valid_reg;
    logic [COUNT_WIDTH-1:0]   m_elapsed_ticks_reg, m_remaining_ticks_reg, m_loop_count_reg;
    logic                     m_timed_out_reg, m_divide_error_reg;
    logic [FRACTION_BITS:0]   m_progress_fraction_reg;
    logic [FRACTION_BITS-1:0] m_loop_fraction_reg;

    logic [COUNT_WIDTH:0]     rem_shift, rem_diff;
    logic                     ge;
    logic [COUNT_WIDTH-1:0]   lcount;

    assign start_next   = s_restart ? s_now_count : start_reg;
    assign elapsed_next = s_now_count - start_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, div_reg[COUNT_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, timeout_reg};
    assign ge        = (rem_shift >= {1'b0, timeout_reg});
    assign rem_next  = ge ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];

    // an exact multiple of the period counts one loop less
    assign lcount = ((loop_r_reg == '0) && (elapsed_reg != '0)) ?
                    (loop_q_reg - 1'b1) : loop_q_reg;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= '1;
            start_reg   <= '0;
            tout_reg    <= 1'b0;
            derr_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_timeout_period;
            end
            if (cmd.load_item) begin
                start_reg <= start_next;
                tout_reg  <= (elapsed_next >= timeout_reg);
                derr_reg  <= (timeout_reg == '0);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            elapsed_reg   <= elapsed_next;
            remaining_reg <= (elapsed_next > timeout_reg) ? '0 : (timeout_reg - elapsed_next);
            rem_reg       <= '0;
            div_reg       <= elapsed_next;
            quo_reg       <= '0;
        end else if (cmd.save_loop) begin
            loop_q_reg <= quo_reg[COUNT_WIDTH-1:0];
            loop_r_reg <= rem_reg;
            rem_reg    <= elapsed_reg;
            div_reg    <= '0;
            quo_reg    <= '0;
        end else if (cmd.save_prog) begin
            prog_q_reg <= quo_reg[FRACTION_BITS-1:0];
            rem_reg    <= loop_r_reg;
            div_reg    <= '0;
            quo_reg    <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            div_reg <= {div_reg[COUNT_WIDTH-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end

        if (cmd.out_load) begin
            m_elapsed_ticks_reg     <= elapsed_reg;
            m_remaining_ticks_reg   <= remaining_reg;
            m_timed_out_reg         <= tout_reg;
            m_progress_fraction_reg <= tout_reg ? {1'b1, {FRACTION_BITS{1'b0}}}
                                                : {1'b0, prog_q_reg};
            m_loop_count_reg        <= derr_reg ? '0 : lcount;
            m_loop_fraction_reg     <= derr_reg ? '0 : quo_reg[FRACTION_BITS-1:0];
            m_divide_error_reg      <= derr_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_elapsed_ticks     = m_elapsed_ticks_reg;
    assign m_remaining_ticks   = m_remaining_ticks_reg;
    assign m_timed_out         = m_timed_out_reg;
    assign m_progress_fraction = m_progress_fraction_reg;
    assign m_loop_count        = m_loop_count_reg;
    assign m_loop_fraction     = m_loop_fraction_reg;
    assign m_divide_error      = m_divide_error_reg;

    `WIT_ASSERT(a_derr_implies_tout, aclk, aresetn, !derr_reg || tout_reg)
    `WIT_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.out_load, m_valid_reg)
    `WIT_ASSERT(a_derr_zero_loops, aclk, aresetn,
        !(m_valid_reg && m_divide_error_reg) || (m_timed_out_reg && m_loop_count_reg == '0))

endmodule

`default_nettype wire

// ===== rtl/core/wraparound_interval_timer_unit.sv =====
// top level of the wraparound interval timer: wit_ctrl plus wit_datapath
// depends on wit_pkg
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   cfg      | cfg_valid/cfg_ready  | cfg_timeout_period
//   s_ input | s_valid/s_ready      | s_now_count, s_restart
//   m_ result| m_valid/m_ready      | elapsed, remaining, timed_out, fractions,
//            |                      | loop_count, divide_error
//
// each transaction passes through the single shared restoring divider:
// one long division for the loop count, then two fraction divisions,
// one quotient bit per cycle.
// a new input is taken while a result waits in the output register; the
// controller stalls only in its last state until that register is free.
// reset is synchronous, active low; the timeout resets to all ones, start mark to 0.
`timescale 1ns / 1ps
`default_nettype none

module wraparound_interval_timer_unit #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [COUNT_WIDTH-1:0]     cfg_timeout_period,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [COUNT_WIDTH-1:0]     s_now_count,
    input  wire logic                       s_restart,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [COUNT_WIDTH-1:0]          m_elapsed_ticks,
    output logic [COUNT_WIDTH-1:0]          m_remaining_ticks,
    output logic                            m_timed_out,
    output logic [FRACTION_BITS:0]          m_progress_fraction,
    output logic [COUNT_WIDTH-1:0]          m_loop_count,
    output logic [FRACTION_BITS-1:0]        m_loop_fraction,
    output logic                            m_divide_error
);
    import wit_pkg::*;

    wit_cmd_t    cmd;
    wit_status_t status;

    assign cfg_ready = 1'b1;

    wit_ctrl #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wit_datapath #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_timeout_period  (cfg_timeout_period),
        .s_now_count         (s_now_count),
        .s_restart           (s_restart),
        .cmd                 (cmd),
        .status              (status),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_elapsed_ticks     (m_elapsed_ticks),
        .m_remaining_ticks   (m_remaining_ticks),
        .m_timed_out         (m_timed_out),
        .m_progress_fraction (m_progress_fraction),
        .m_loop_count        (m_loop_count),
        .m_loop_fraction     (m_loop_fraction),
        .m_divide_error      (m_divide_error)
    );

endmodule

`default_nettype wire
